// ===== src/coordinate_barcode_parser_assert.svh =====
// Assertion helpers shared by the checker.
`ifndef COORDINATE_BARCODE_PARSER_ASSERT_SVH
`define COORDINATE_BARCODE_PARSER_ASSERT_SVH

// Same-cycle implication.
`define CBP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cbp assertion failed");

// Next-cycle implication.
`define CBP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cbp assertion failed");

`endif

// ===== src/cbp_pkg.sv =====
`timescale 1ns / 1ps
package cbp_pkg;

   typedef enum logic [2:0] {
      PH_PREFIX = 3'd0,
      PH_ROW    = 3'd1,
      PH_COL    = 3'd2,
      PH_TAIL   = 3'd3,
      PH_FAIL   = 3'd4
   } phase_type;

   localparam int unsigned PREFIX_LEN = 8;

   localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CHAR_HYPHEN     = 8'h2D;
   localparam logic [7:0] CHAR_ZERO       = 8'h30;
   localparam logic [7:0] CHAR_NINE       = 8'h39;

   localparam logic [31:0] ACC_LIMIT       = 32'd429496729;
   localparam logic [3:0]  ACC_LIMIT_DIGIT = 4'd5;

   function automatic logic [7:0] prefix_char(input logic [2:0] pos);
      logic [7:0] c;
      case (pos)
         3'd0:    c = 8'h73;
         3'd1:    c = 8'h5F;
         3'd2:    c = 8'h30;
         3'd3:    c = 8'h30;
         3'd4:    c = 8'h32;
         3'd5:    c = 8'h75;
         3'd6:    c = 8'h6D;
         3'd7:    c = 8'h5F;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

// ===== src/cbp_req_if.sv =====
`timescale 1ns / 1ps
interface cbp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       is_last;

   modport source (output valid, output char_code, output is_last, input ready);
   modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

// ===== src/cbp_rsp_if.sv =====
`timescale 1ns / 1ps
interface cbp_rsp_if;
   logic        valid;
   logic        ready;
   logic        parse_ok;
   logic [31:0] row_number;
   logic [31:0] column_number;

   modport source (output valid, output parse_ok, output row_number,
                   output column_number, input ready);
   modport sink   (input valid, input parse_ok, input row_number,
                   input column_number, output ready);
endinterface

// ===== src/coordinate_barcode_parser.sv =====
`timescale 1ns / 1ps
// Coordinate barcode parser.
// req_chan carries one barcode character per transaction (char_code) and
// is_last on the final character. The barcode must open with the fixed
// eight-character prefix held in cbp_pkg::prefix_char, then a decimal row
// ended by '_', then a decimal column ended by '-' or by the end; anything
// after the hyphen is ignored.
// rsp_chan carries one transaction per barcode, after its last character:
// parse_ok, row_number and column_number (both zero when parse_ok is 0).
// Throughput: one character per cycle while no finished result waits on a stalled
// receiver, set by the single parse stage (a compare plus a multiply-by-ten
// accumulate between the input register and the parser state and result registers).
// The last character is held in the input register; the result register loads
// from it when the parse stage proceeds, and drives the result transaction.
// When the receiver stalls, the result register holds; characters keep
// flowing until a second last character reaches the parse stage, which then
// waits and backs req_chan.ready off.
// Reset (synchronous, active high) empties both registers and returns the
// parser to prefix matching at the start of a barcode.
module coordinate_barcode_parser (
   input  logic      clock,
   input  logic      reset,
   cbp_req_if.sink   req_chan,
   cbp_rsp_if.source rsp_chan
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_char_ff;
   logic       in_last_ff;

   cbp_pkg::phase_type phase_ff, phase_in;
   logic [2:0]  pos_ff, pos_in;
   logic [31:0] row_ff, row_in;
   logic [31:0] col_ff, col_in;
   logic        row_seen_ff, row_seen_in;
   logic        col_seen_ff, col_seen_in;
   logic        ovf_ff, ovf_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_ok_ff;
   logic [31:0] rsp_row_ff;
   logic [31:0] rsp_col_ff;

   logic        in_fire;
   logic        proceed;
   logic        is_digit;
   logic [3:0]  digit;
   logic [31:0] acc_sel;
   logic [31:0] acc_next;
   logic        acc_ovf;
   logic        ok;

   assign in_fire = req_chan.valid && req_chan.ready;
   assign proceed = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || proceed;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (in_fire) begin
         in_valid_in = 1'b1;
      end else if (proceed) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_fire) begin
         in_char_ff <= req_chan.char_code;
         in_last_ff <= req_chan.is_last;
      end
   end

   assign is_digit = in_char_ff inside {[cbp_pkg::CHAR_ZERO:cbp_pkg::CHAR_NINE]};
   assign digit    = in_char_ff[3:0];
   assign acc_sel  = (phase_ff == cbp_pkg::PH_COL) ? col_ff : row_ff;
   assign acc_ovf  = (acc_sel > cbp_pkg::ACC_LIMIT) ||
                     ((acc_sel == cbp_pkg::ACC_LIMIT) && (digit > cbp_pkg::ACC_LIMIT_DIGIT));
   assign acc_next = {acc_sel[28:0], 3'b000} + {acc_sel[30:0], 1'b0} + {28'd0, digit};

   always_comb begin
      phase_in    = phase_ff;
      pos_in      = pos_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      row_seen_in = row_seen_ff;
      col_seen_in = col_seen_ff;
      ovf_in      = ovf_ff;
      case (phase_ff)
         cbp_pkg::PH_PREFIX: begin
            if (in_char_ff == cbp_pkg::prefix_char(pos_ff)) begin
               pos_in = pos_ff + 3'd1;
               if (pos_ff == 3'(cbp_pkg::PREFIX_LEN - 1)) begin
                  phase_in = cbp_pkg::PH_ROW;
               end
            end else begin
               phase_in = cbp_pkg::PH_FAIL;
            end
         end
         cbp_pkg::PH_ROW: begin
            if (in_char_ff == cbp_pkg::CHAR_UNDERSCORE) begin
               phase_in = row_seen_ff ? cbp_pkg::PH_COL : cbp_pkg::PH_FAIL;
            end else if (is_digit) begin
               row_seen_in = 1'b1;
               if (acc_ovf) begin
                  ovf_in = 1'b1;
               end else begin
                  row_in = acc_next;
               end
            end else begin
               phase_in = cbp_pkg::PH_FAIL;
            end
         end
         cbp_pkg::PH_COL: begin
            if (in_char_ff == cbp_pkg::CHAR_HYPHEN) begin
               phase_in = col_seen_ff ? cbp_pkg::PH_TAIL : cbp_pkg::PH_FAIL;
            end else if (is_digit) begin
               col_seen_in = 1'b1;
               if (acc_ovf) begin
                  ovf_in = 1'b1;
               end else begin
                  col_in = acc_next;
               end
            end else begin
               phase_in = cbp_pkg::PH_FAIL;
            end
         end
         cbp_pkg::PH_TAIL: begin
            phase_in = cbp_pkg::PH_TAIL;
         end
         default: begin
            phase_in = cbp_pkg::PH_FAIL;
         end
      endcase
   end

   assign ok = ((phase_in == cbp_pkg::PH_TAIL) ||
                ((phase_in == cbp_pkg::PH_COL) && col_seen_in)) && !ovf_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= cbp_pkg::PH_PREFIX;
         pos_ff      <= 3'd0;
         row_ff      <= 32'd0;
         col_ff      <= 32'd0;
         row_seen_ff <= 1'b0;
         col_seen_ff <= 1'b0;
         ovf_ff      <= 1'b0;
      end else if (proceed) begin
         if (in_last_ff) begin
            phase_ff    <= cbp_pkg::PH_PREFIX;
            pos_ff      <= 3'd0;
            row_ff      <= 32'd0;
            col_ff      <= 32'd0;
            row_seen_ff <= 1'b0;
            col_seen_ff <= 1'b0;
            ovf_ff      <= 1'b0;
         end else begin
            phase_ff    <= phase_in;
            pos_ff      <= pos_in;
            row_ff      <= row_in;
            col_ff      <= col_in;
            row_seen_ff <= row_seen_in;
            col_seen_ff <= col_seen_in;
            ovf_ff      <= ovf_in;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (proceed && in_last_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (proceed && in_last_ff) begin
         rsp_ok_ff  <= ok;
         rsp_row_ff <= ok ? row_in : 32'd0;
         rsp_col_ff <= ok ? col_in : 32'd0;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.parse_ok      = rsp_ok_ff;
   assign rsp_chan.row_number    = rsp_row_ff;
   assign rsp_chan.column_number = rsp_col_ff;

endmodule

// ===== src/cbp_checker.sv =====
`timescale 1ns / 1ps
`include "coordinate_barcode_parser_assert.svh"
module cbp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_parse_ok,
   input logic [31:0] rsp_row_number,
   input logic [31:0] rsp_column_number
);

   logic        rsp_stall;
   logic        rsp_fail;
   logic [64:0] rsp_payload;

   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign rsp_fail    = rsp_valid && !rsp_parse_ok;
   assign rsp_payload = {rsp_parse_ok, rsp_row_number, rsp_column_number};

   // hold a stalled transaction
   `CBP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_payload))

   `CBP_ASSERT_IMPLY(a_fail_zero, clock, reset, rsp_fail, (rsp_payload[63:0] == 64'd0))

   `CBP_ASSERT_IMPLY(a_ready_free, clock, reset, !rsp_valid, req_ready)

   `CBP_ASSERT_NEXT(a_reset_ready, clock, 1'b0, reset, req_ready)

   `CBP_ASSERT_NEXT(a_reset_clear, clock, 1'b0, reset, !rsp_valid)

endmodule

bind coordinate_barcode_parser cbp_checker u_cbp_checker (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req_chan.ready),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_parse_ok      (rsp_chan.parse_ok),
   .rsp_row_number    (rsp_chan.row_number),
   .rsp_column_number (rsp_chan.column_number)
);

// ===== tb/sv/coordinate_barcode_checker.sv =====
`timescale 1ns / 1ps
module coordinate_barcode_checker (
   input  logic        clock,
   input  logic        reset,
   cbp_req_if          req_chan,
   cbp_rsp_if          rsp_chan,
   output int unsigned mismatches,
   output int unsigned pending_results,
   output int unsigned results_checked,
   output int unsigned parses_ok
);

   localparam logic [63:0] PREFIX_BYTES = 64'h735F_3030_3275_6D5F;

   typedef struct packed {
      logic        parse_ok;
      logic [31:0] row_number;
      logic [31:0] column_number;
   } coord_result_type;

   coord_result_type expected_coords[$];

   cbp_pkg::phase_type phase;
   logic [3:0]  prefix_pos;
   logic [31:0] row_acc;
   logic [31:0] col_acc;
   logic        row_digit_seen;
   logic        col_digit_seen;
   logic        overflow;

   function automatic logic [32:0] times_ten_plus(input logic [31:0] acc,
                                                  input logic [3:0] digit);
      if (acc > cbp_pkg::ACC_LIMIT ||
          (acc == cbp_pkg::ACC_LIMIT && digit > cbp_pkg::ACC_LIMIT_DIGIT)) begin
         return {1'b1, acc};
      end
      return {1'b0, acc * 32'd10 + {28'd0, digit}};
   endfunction

   task automatic clear_parser();
      phase          = cbp_pkg::PH_PREFIX;
      prefix_pos     = '0;
      row_acc        = '0;
      col_acc        = '0;
      row_digit_seen = 1'b0;
      col_digit_seen = 1'b0;
      overflow       = 1'b0;
   endtask

   task automatic take_char(input logic [7:0] ch, input logic last);
      logic             is_digit;
      logic [3:0]       digit;
      logic [32:0]      shifted;
      coord_result_type res;
      is_digit = (ch >= cbp_pkg::CHAR_ZERO) && (ch <= cbp_pkg::CHAR_NINE);
      digit    = 4'(ch - cbp_pkg::CHAR_ZERO);
      case (phase)
         cbp_pkg::PH_PREFIX: begin
            if (prefix_pos < cbp_pkg::PREFIX_LEN &&
                ch == PREFIX_BYTES[63 - 8 * int'(prefix_pos) -: 8]) begin
               prefix_pos = prefix_pos + 4'd1;
               if (prefix_pos == cbp_pkg::PREFIX_LEN) phase = cbp_pkg::PH_ROW;
            end else begin
               phase = cbp_pkg::PH_FAIL;
            end
         end
         cbp_pkg::PH_ROW: begin
            if (ch == cbp_pkg::CHAR_UNDERSCORE) begin
               phase = row_digit_seen ? cbp_pkg::PH_COL : cbp_pkg::PH_FAIL;
            end else if (is_digit) begin
               shifted        = times_ten_plus(row_acc, digit);
               overflow       = overflow | shifted[32];
               row_acc        = shifted[31:0];
               row_digit_seen = 1'b1;
            end else begin
               phase = cbp_pkg::PH_FAIL;
            end
         end
         cbp_pkg::PH_COL: begin
            if (ch == cbp_pkg::CHAR_HYPHEN) begin
               phase = col_digit_seen ? cbp_pkg::PH_TAIL : cbp_pkg::PH_FAIL;
            end else if (is_digit) begin
               shifted        = times_ten_plus(col_acc, digit);
               overflow       = overflow | shifted[32];
               col_acc        = shifted[31:0];
               col_digit_seen = 1'b1;
            end else begin
               phase = cbp_pkg::PH_FAIL;
            end
         end
         cbp_pkg::PH_TAIL: begin
         end
         default: begin
            phase = cbp_pkg::PH_FAIL;
         end
      endcase
      if (last) begin
         res.parse_ok      = (phase == cbp_pkg::PH_TAIL ||
                              (phase == cbp_pkg::PH_COL && col_digit_seen)) && !overflow;
         res.row_number    = res.parse_ok ? row_acc : 32'd0;
         res.column_number = res.parse_ok ? col_acc : 32'd0;
         expected_coords.insert(expected_coords.size(), res);
         clear_parser();
      end
   endtask

   task automatic compare_result();
      coord_result_type exp;
      if (expected_coords.size() == 0) begin
         $error("unexpected transaction: parse_ok=%0d row_number=%0d column_number=%0d",
                rsp_chan.parse_ok, rsp_chan.row_number, rsp_chan.column_number);
         mismatches++;
      end else begin
         exp = expected_coords.pop_front();
         if (rsp_chan.parse_ok !== exp.parse_ok) begin
            $error("parse_ok: expected %0d, actual %0d", exp.parse_ok, rsp_chan.parse_ok);
            mismatches++;
         end
         if (rsp_chan.row_number !== exp.row_number) begin
            $error("row_number: expected %0d, actual %0d",
                   exp.row_number, rsp_chan.row_number);
            mismatches++;
         end
         if (rsp_chan.column_number !== exp.column_number) begin
            $error("column_number: expected %0d, actual %0d",
                   exp.column_number, rsp_chan.column_number);
            mismatches++;
         end
         results_checked++;
         if (exp.parse_ok) parses_ok++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_parser();
         expected_coords.delete();
         mismatches      = 0;
         results_checked = 0;
         parses_ok       = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) compare_result();
         if (req_chan.valid && req_chan.ready) take_char(req_chan.char_code, req_chan.is_last);
      end
      pending_results = expected_coords.size();
   end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
module tb;

   localparam int          ITEM_TARGET     = 1700;
   localparam int          IDLE_PCT        = 37;
   localparam int          HOLD_OFF_CYCLES = 200;
   localparam int          DRAIN_CYCLES    = 10;
   localparam logic [63:0] PREFIX_BYTES    = 64'h735F_3030_3275_6D5F;

   typedef enum int {
      FLAW_NONE,
      FLAW_EMPTY_ROW,
      FLAW_EMPTY_COLUMN,
      FLAW_TRAILING_UNDERSCORE,
      FLAW_SIGN,
      FLAW_HYPHEN_IN_ROW,
      FLAW_SECOND_UNDERSCORE,
      FLAW_CORRUPT_BYTE,
      FLAW_TRUNCATE
   } flaw_type;

   typedef enum int {
      NUM_SHORT,
      NUM_FULL_RANGE,
      NUM_NEAR_LIMIT,
      NUM_LEADING_ZEROS,
      NUM_TOO_LONG
   } number_kind_type;

   logic        clock = 1'b0;
   logic        reset;
   int          idle_pct;
   bit          hold_off_req;
   int          chars_sent;
   int          barcodes_sent;
   logic [7:0]  barcode[$];
   int unsigned mismatches;
   int unsigned pending_results;
   int unsigned results_checked;
   int unsigned parses_ok;

   cbp_req_if req_chan ();
   cbp_rsp_if rsp_chan ();

   coordinate_barcode_parser i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   coordinate_barcode_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_chan        (req_chan),
      .rsp_chan        (rsp_chan),
      .mismatches      (mismatches),
      .pending_results (pending_results),
      .results_checked (results_checked),
      .parses_ok       (parses_ok)
   );

   always #5 clock = ~clock;

   initial begin
      #4_000_000;
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end
         rsp_chan.ready <= ($urandom_range(0, 99) >= idle_pct);
      end
   end

   task automatic send_char(input logic [7:0] ch, input logic last);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.char_code <= ch;
      req_chan.is_last   <= last;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
      chars_sent++;
   endtask

   task automatic send_barcode();
      for (int i = 0; i < barcode.size(); i++) begin
         send_char(barcode[i], i == barcode.size() - 1);
      end
      barcodes_sent++;
   endtask

   task automatic append_byte(input logic [7:0] b);
      barcode.insert(barcode.size(), b);
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) append_byte(s[i]);
   endtask

   task automatic push_prefix(input int count);
      for (int i = 0; i < count; i++) append_byte(PREFIX_BYTES[63 - 8 * i -: 8]);
   endtask

   task automatic push_digit();
      append_byte(cbp_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
   endtask

   task automatic push_value(input logic [31:0] value);
      logic [7:0] digits[$];
      if (value == 0) digits.push_front(cbp_pkg::CHAR_ZERO);
      while (value != 0) begin
         digits.push_front(cbp_pkg::CHAR_ZERO + 8'(value % 10));
         value = value / 10;
      end
      foreach (digits[i]) append_byte(digits[i]);
   endtask

   task automatic push_number();
      number_kind_type kind;
      kind = number_kind_type'($urandom_range(0, 4));
      case (kind)
         NUM_SHORT:      repeat ($urandom_range(1, 4)) push_digit();
         NUM_FULL_RANGE: push_value($urandom);
         NUM_NEAR_LIMIT: begin
            push_text("429496729");
            push_digit();
         end
         NUM_LEADING_ZEROS: begin
            repeat ($urandom_range(1, 3)) append_byte(cbp_pkg::CHAR_ZERO);
            push_value($urandom_range(0, 99));
         end
         default: repeat ($urandom_range(11, 13)) push_digit();
      endcase
   endtask

   task automatic build_random_barcode();
      int       roll;
      int       keep;
      flaw_type flaw;
      barcode.delete();
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
         if ($urandom_range(0, 1)) push_prefix($urandom_range(1, 7));
         repeat ($urandom_range(1, 12)) append_byte(8'($urandom_range(0, 255)));
         return;
      end
      flaw = (roll < 70) ? FLAW_NONE : flaw_type'($urandom_range(1, 8));
      push_prefix(cbp_pkg::PREFIX_LEN);
      if (flaw == FLAW_SIGN) begin
         case ($urandom_range(0, 3))
            0:       push_text(" ");
            1:       push_text("+");
            2:       push_text("-");
            default: push_text("\t");
         endcase
      end
      if (flaw != FLAW_EMPTY_ROW) push_number();
      if (flaw == FLAW_HYPHEN_IN_ROW) begin
         append_byte(cbp_pkg::CHAR_HYPHEN);
         push_number();
      end
      append_byte(cbp_pkg::CHAR_UNDERSCORE);
      if (flaw == FLAW_TRAILING_UNDERSCORE) return;
      if (flaw != FLAW_EMPTY_COLUMN) push_number();
      if (flaw == FLAW_SECOND_UNDERSCORE) begin
         append_byte(cbp_pkg::CHAR_UNDERSCORE);
         push_number();
      end
      if ($urandom_range(0, 2) != 0) begin
         append_byte(cbp_pkg::CHAR_HYPHEN);
         repeat ($urandom_range(0, 4)) append_byte(8'($urandom_range(0, 255)));
      end
      if (flaw == FLAW_CORRUPT_BYTE) begin
         barcode[$urandom_range(0, barcode.size() - 1)] = 8'($urandom_range(0, 255));
      end
      if (flaw == FLAW_TRUNCATE) begin
         keep = $urandom_range(1, barcode.size() - 1);
         while (barcode.size() > keep) void'(barcode.pop_back());
      end
   endtask

   initial begin
      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.char_code = 8'd0;
      req_chan.is_last   = 1'b0;
      idle_pct           = IDLE_PCT;
      hold_off_req       = 1'b0;
      chars_sent         = 0;
      barcodes_sent      = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // wrong first byte, NUL inside a short prefix, largest row with column zero
      barcode.delete();
      append_byte(8'hFF);
      send_barcode();
      barcode.delete();
      push_prefix(2);
      append_byte(8'h00);
      send_barcode();
      barcode.delete();
      push_prefix(cbp_pkg::PREFIX_LEN);
      push_text("4294967295_0-");
      send_barcode();

      while (chars_sent < ITEM_TARGET) begin
         if (barcodes_sent == 12) hold_off_req = 1'b1;
         if (barcodes_sent == 25) begin
            req_chan.valid <= 1'b0;
            do @(negedge clock); while (pending_results != 0);
         end
         idle_pct = (barcodes_sent >= 40 && barcodes_sent < 52) ? 0 : IDLE_PCT;
         build_random_barcode();
         send_barcode();
      end

      // drain outstanding transactions
      req_chan.valid <= 1'b0;
      do @(negedge clock); while (pending_results != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Sent %0d barcodes in %0d characters; checked %0d results,",
               barcodes_sent, chars_sent, results_checked);
      $display("%0d parsed to coordinates, across random stalls on both channels.", parses_ok);
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+src
src/cbp_pkg.sv
src/cbp_req_if.sv
src/cbp_rsp_if.sv
src/coordinate_barcode_parser.sv
src/cbp_checker.sv
tb/sv/coordinate_barcode_checker.sv
tb/sv/tb.sv
